/* sv/tsq_pkg.sv */
// Shared types and constants for the two-stack queue.
// Used by tsq_ctrl, tsq_dpath and two_stack_queue_core; depends on nothing.
`default_nettype none

package tsq_pkg;

  // Stack geometry
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  // Request kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_ENQ   = 2'd0;
  localparam logic [1:0] STAT_DEQ   = 2'd1;
  localparam logic [1:0] STAT_UNDER = 2'd2;
  localparam logic [1:0] STAT_OVER  = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_POP
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       push;        // write request byte onto input stack
    logic       pop;         // read top of output stack, shrink it
    logic       move_rd;     // read top of input stack for transfer, shrink it
    logic       load_res;    // load result register
    logic [1:0] res_status;  // status code to load
  } tsq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_empty;
    logic in_full;
    logic out_empty;
    logic mv_pend;   // transfer write still in flight
    logic res_free;  // result register empty or being taken this cycle
  } tsq_sts_t;

endpackage

`default_nettype wire

/* sv/tsq_ctrl.sv */
// Controller state machine for the two-stack queue.
// Depends on tsq_pkg; drives tsq_dpath through tsq_cmd_t and reads tsq_sts_t.
`default_nettype none

module tsq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic              kind,
  input  wire tsq_pkg::tsq_sts_t sts,
  output tsq_pkg::tsq_cmd_t      cmd
);

  tsq_pkg::ctrl_state_t state;
  tsq_pkg::ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = (state == tsq_pkg::ST_IDLE) && sts.res_free;
    case (state)
      tsq_pkg::ST_IDLE: begin
        if (req_valid && req_ready) begin
          if (kind == tsq_pkg::KIND_ENQ) begin
            cmd.load_res = 1'b1;
            if (sts.in_full) begin
              cmd.res_status = tsq_pkg::STAT_OVER;
            end else begin
              cmd.push       = 1'b1;
              cmd.res_status = tsq_pkg::STAT_ENQ;
            end
          end else if (!sts.out_empty) begin
            cmd.pop    = 1'b1;
            state_next = tsq_pkg::ST_POP;
          end else if (sts.in_empty) begin
            cmd.load_res   = 1'b1;
            cmd.res_status = tsq_pkg::STAT_UNDER;
          end else begin
            state_next = tsq_pkg::ST_MOVE;
          end
        end
      end
      // Drain input stack onto output stack, one element per cycle
      tsq_pkg::ST_MOVE: begin
        if (!sts.in_empty) begin
          cmd.move_rd = 1'b1;
        end else if (!sts.mv_pend) begin
          cmd.pop    = 1'b1;
          state_next = tsq_pkg::ST_POP;
        end
      end
      // Popped byte is in the read register now
      tsq_pkg::ST_POP: begin
        cmd.load_res   = 1'b1;
        cmd.res_status = tsq_pkg::STAT_DEQ;
        state_next     = tsq_pkg::ST_IDLE;
      end
      default: begin
        state_next = tsq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/tsq_dpath.sv */
// Datapath for the two-stack queue: both stack memories, their counts,
// the transfer stage and the result register. Depends on tsq_pkg.
`default_nettype none

module tsq_dpath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        data_value,
  input  wire tsq_pkg::tsq_cmd_t cmd,
  output tsq_pkg::tsq_sts_t      sts,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output logic [1:0]             status,
  output logic [7:0]             result_value
);

  logic [7:0]              in_mem  [tsq_pkg::DEPTH];
  logic [7:0]              out_mem [tsq_pkg::DEPTH];
  logic [tsq_pkg::CNT_W-1:0] in_count;
  logic [tsq_pkg::CNT_W-1:0] out_count;
  logic [tsq_pkg::CNT_W-1:0] in_top;
  logic [tsq_pkg::CNT_W-1:0] out_top;
  logic [7:0]              in_rdata;
  logic [7:0]              out_rdata;
  logic                    mv_pend;

  assign in_top  = in_count - tsq_pkg::CNT_W'(1);
  assign out_top = out_count - tsq_pkg::CNT_W'(1);

  // Input stack memory
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      in_mem[in_count[tsq_pkg::PTR_W-1:0]] <= data_value;
    end
    if (cmd.move_rd) begin
      in_rdata <= in_mem[in_top[tsq_pkg::PTR_W-1:0]];
    end
  end

  // Output stack memory; the transfer write lands in the cycle after its read
  always_ff @(posedge clk) begin
    if (mv_pend) begin
      out_mem[out_count[tsq_pkg::PTR_W-1:0]] <= in_rdata;
    end
    if (cmd.pop) begin
      out_rdata <= out_mem[out_top[tsq_pkg::PTR_W-1:0]];
    end
  end

  // Stack counts and transfer pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= '0;
      out_count <= '0;
      mv_pend   <= 1'b0;
    end else begin
      mv_pend <= cmd.move_rd;
      if (cmd.push) begin
        in_count <= in_count + tsq_pkg::CNT_W'(1);
      end else if (cmd.move_rd) begin
        in_count <= in_top;
      end
      if (mv_pend) begin
        out_count <= out_count + tsq_pkg::CNT_W'(1);
      end else if (cmd.pop) begin
        out_count <= out_top;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_res) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      status       <= cmd.res_status;
      result_value <= (cmd.res_status == tsq_pkg::STAT_DEQ) ? out_rdata : 8'd0;
    end
  end

  // Status to controller
  always_comb begin
    sts.in_empty  = (in_count == '0);
    sts.in_full   = (in_count == tsq_pkg::CNT_W'(tsq_pkg::DEPTH));
    sts.out_empty = (out_count == '0);
    sts.mv_pend   = mv_pend;
    sts.res_free  = !rsp_valid || rsp_ready;
  end

endmodule

`default_nettype wire

/* sv/two_stack_queue_core.sv */
// FIFO of bytes built from two 16-entry stacks. Each request (enqueue or
// dequeue) yields one response with a status: enqueued, dequeued byte,
// underflow, or overflow (enqueue dropped when the input stack is full,
// even if the output stack has room). Enqueue, overflow and underflow load
// the response register as soon as they are taken; a dequeue served from a
// non-empty output stack first passes through the registered read of the
// stack memory. A dequeue that finds the output stack empty first moves all
// n entries of the input stack across, one per cycle through the memory
// read register. A new request is taken once the previous one is done
// and the response register is free or being emptied.
// Depends on tsq_pkg, tsq_ctrl and tsq_dpath.
`default_nettype none

module two_stack_queue_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic       kind,
  input  wire logic [7:0] data_value,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output logic [1:0]      status,
  output logic [7:0]      result_value
);

  tsq_pkg::tsq_cmd_t cmd;
  tsq_pkg::tsq_sts_t sts;

  tsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .kind      (kind),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsq_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .data_value   (data_value),
    .cmd          (cmd),
    .sts          (sts),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .result_value (result_value)
  );

`ifndef NO_ASSERTIONS
  // At most one stack operation per cycle
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.pop, cmd.move_rd}))
    else $error("more than one stack operation in a cycle");

  // Never push onto a full input stack
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    sts.in_full |-> !cmd.push)
    else $error("push onto full input stack");

  // Never pop an empty output stack
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    sts.out_empty |-> !cmd.pop)
    else $error("pop from empty output stack");

  // Only a dequeued response carries a byte
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != tsq_pkg::STAT_DEQ) |-> (result_value == 8'd0))
    else $error("nonzero value on non-dequeue response");
`endif

endmodule

`default_nettype wire
